[design/sdl_pkg.sv]
`timescale 1ns / 1ps

package sdl_pkg;

  localparam int BinW   = 9;
  localparam int MagW   = 32;
  localparam int MsbW   = 5;
  localparam int FracW  = 16;
  localparam int LvlW   = 16;
  localparam int FactW  = 17;
  localparam int DataW  = 32;
  localparam int AddrW  = 3;
  localparam int ProdW  = 52;
  localparam int BiasW  = 53;
  localparam int BlendW = 32;

  // log10(2)/2 in Q0.32.
  localparam logic [29:0] LogScale = 30'd646456993;
  // Offset of one half plus rounding, both in the Q.48 product scale.
  localparam logic signed [BiasW-1:0] LevelBias = 53'sh0_8000_8000_0000;

  localparam logic [FactW-1:0]  Unity      = 17'h10000;
  localparam logic [BlendW-1:0] BlendRound = 32'h0000_8000;

  // Register index taken from the word address.
  localparam logic RegAvgFactor = 1'b0;

  typedef struct packed {
    logic [BinW-1:0] bin;
    logic [MsbW-1:0] msb;
    logic            zero;
    logic [MagW-1:0] x;
  } norm_item_t;

  typedef struct packed {
    logic [BinW-1:0]  bin;
    logic [MsbW-1:0]  msb;
    logic             zero;
    logic [FracW-1:0] frac;
  } log_item_t;

  typedef struct packed {
    logic [BinW-1:0] bin;
    logic [LvlW-1:0] level;
  } lvl_item_t;

endpackage

[design/sdl_norm.sv]
`timescale 1ns / 1ps

module sdl_norm (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sdl_pkg::BinW-1:0]     bin_i,
  input  logic [sdl_pkg::MagW-1:0]     mag_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output sdl_pkg::norm_item_t          out_item_o
);

  logic [1:0] v_q;
  logic [1:0] take;

  logic [sdl_pkg::MsbW-1:0] msb_d;
  logic [sdl_pkg::BinW-1:0] bin0_q;
  logic [sdl_pkg::MsbW-1:0] msb0_q;
  logic                     zero0_q;
  logic [sdl_pkg::MagW-1:0] mag0_q;
  sdl_pkg::norm_item_t      item_q;

  assign take[1] = !v_q[1] || !out_stall_i;
  assign take[0] = !v_q[0] || take[1];

  always_comb begin
    msb_d = '0;
    for (int i = 0; i < sdl_pkg::MagW; i++) begin
      if (mag_i[i]) begin
        msb_d = sdl_pkg::MsbW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (take[0]) begin
        v_q[0] <= in_valid_i;
      end
      if (take[1]) begin
        v_q[1] <= v_q[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take[0]) begin
      bin0_q  <= bin_i;
      msb0_q  <= msb_d;
      zero0_q <= (mag_i == '0);
      mag0_q  <= mag_i;
    end
    if (take[1]) begin
      item_q.bin  <= bin0_q;
      item_q.msb  <= msb0_q;
      item_q.zero <= zero0_q;
      item_q.x    <= mag0_q << (sdl_pkg::MsbW'(sdl_pkg::MagW - 1) - msb0_q);
    end
  end

  assign in_stall_o  = !take[0];
  assign out_valid_o = v_q[1];
  assign out_item_o  = item_q;

endmodule

[design/sdl_log2.sv]
`timescale 1ns / 1ps

module sdl_log2 (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sdl_pkg::norm_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sdl_pkg::log_item_t   out_item_o
);

  localparam int N = sdl_pkg::FracW;

  logic [N-1:0] v_q;
  logic [N-1:0] take;

  sdl_pkg::log_item_t       item_q [N];
  logic [sdl_pkg::MagW-1:0] x_q    [N];
  sdl_pkg::log_item_t       item_d [N];
  logic [sdl_pkg::MagW-1:0] x_d    [N];

  always_comb begin
    take[N-1] = !v_q[N-1] || !out_stall_i;
    for (int k = N - 2; k >= 0; k--) begin
      take[k] = !v_q[k] || take[k+1];
    end
  end

  // Each stage squares the Q1.31 mantissa once and yields one fraction bit.
  always_comb begin
    logic [sdl_pkg::MagW-1:0]   src_x;
    sdl_pkg::log_item_t         src;
    logic [2*sdl_pkg::MagW-1:0] sq;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        src.bin  = in_item_i.bin;
        src.msb  = in_item_i.msb;
        src.zero = in_item_i.zero;
        src.frac = '0;
        src_x    = in_item_i.x;
      end else begin
        src   = item_q[k-1];
        src_x = x_q[k-1];
      end
      sq = (2*sdl_pkg::MagW)'(src_x) * (2*sdl_pkg::MagW)'(src_x);
      item_d[k]      = src;
      item_d[k].frac = {src.frac[sdl_pkg::FracW-2:0], sq[2*sdl_pkg::MagW-1]};
      x_d[k] = sq[2*sdl_pkg::MagW-1] ? sq[2*sdl_pkg::MagW-1:sdl_pkg::MagW]
                                     : sq[2*sdl_pkg::MagW-2:sdl_pkg::MagW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (take[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      if (take[k]) begin
        item_q[k] <= item_d[k];
        x_q[k]    <= x_d[k];
      end
    end
  end

  assign in_stall_o  = !take[0];
  assign out_valid_o = v_q[N-1];
  assign out_item_o  = item_q[N-1];

endmodule

[design/sdl_level.sv]
`timescale 1ns / 1ps

module sdl_level (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sdl_pkg::log_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sdl_pkg::lvl_item_t  out_item_o
);

  logic [1:0] v_q;
  logic [1:0] take;

  logic signed [sdl_pkg::MsbW+sdl_pkg::FracW-1:0] log_s;
  logic signed [30:0]                             scale_s;
  logic signed [sdl_pkg::ProdW-1:0]               prod_d;
  logic signed [sdl_pkg::ProdW-1:0]               prod_q;
  logic [sdl_pkg::BinW-1:0]                       bin0_q;
  logic                                           zero0_q;
  logic signed [sdl_pkg::BiasW-1:0]               t;
  logic [sdl_pkg::LvlW-1:0]                       level_d;
  sdl_pkg::lvl_item_t                             item_q;

  assign take[1] = !v_q[1] || !out_stall_i;
  assign take[0] = !v_q[0] || take[1];

  // The integer part msb - 16 is the msb with its top bit flipped.
  assign log_s   = $signed({~in_item_i.msb[sdl_pkg::MsbW-1],
                            in_item_i.msb[sdl_pkg::MsbW-2:0], in_item_i.frac});
  assign scale_s = $signed({1'b0, sdl_pkg::LogScale});
  assign prod_d  = log_s * scale_s;

  assign t = $signed({prod_q[sdl_pkg::ProdW-1], prod_q}) + sdl_pkg::LevelBias;

  always_comb begin
    if (zero0_q || t[sdl_pkg::BiasW-1]) begin
      level_d = '0;
    end else if (|t[sdl_pkg::BiasW-2:48]) begin
      level_d = '1;
    end else begin
      level_d = t[47:32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (take[0]) begin
        v_q[0] <= in_valid_i;
      end
      if (take[1]) begin
        v_q[1] <= v_q[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take[0]) begin
      prod_q  <= prod_d;
      bin0_q  <= in_item_i.bin;
      zero0_q <= in_item_i.zero;
    end
    if (take[1]) begin
      item_q.bin   <= bin0_q;
      item_q.level <= level_d;
    end
  end

  assign in_stall_o  = !take[0];
  assign out_valid_o = v_q[1];
  assign out_item_o  = item_q;

endmodule

[design/sdl_blend.sv]
`timescale 1ns / 1ps

module sdl_blend #(
  parameter int NUM_BINS = 512
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [sdl_pkg::FactW-1:0]  factor_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  sdl_pkg::lvl_item_t         in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [sdl_pkg::BinW-1:0]   out_bin_o,
  output logic [sdl_pkg::LvlW-1:0]   out_level_o,
  output logic                       clr_busy_o
);

  localparam int AW = $clog2(NUM_BINS);

  logic [2:0] v_q;
  logic [2:0] take;

  logic [sdl_pkg::FactW-1:0]  f;
  logic [sdl_pkg::BlendW-1:0] lf_q;
  logic [sdl_pkg::FactW-1:0]  g_q;
  logic [sdl_pkg::BinW-1:0]   bin_c_q;
  logic                       inr_c_q;

  logic [sdl_pkg::BlendW-1:0] lf_r_q;
  logic [sdl_pkg::FactW-1:0]  g_r_q;
  logic [sdl_pkg::BinW-1:0]   bin_r_q;
  logic                       inr_r_q;
  logic [sdl_pkg::LvlW-1:0]   rdata_q;
  logic                       fwd_q;
  logic [sdl_pkg::LvlW-1:0]   fwd_val_q;

  logic [sdl_pkg::LvlW-1:0]   prev;
  logic [sdl_pkg::BlendW-1:0] sum;
  logic [sdl_pkg::LvlW-1:0]   smoothed;
  logic                       wr_en;

  logic [sdl_pkg::BinW-1:0]   out_bin_q;
  logic [sdl_pkg::LvlW-1:0]   out_level_q;

  logic [sdl_pkg::LvlW-1:0]   mem [NUM_BINS];
  logic                       clr_busy_q;
  logic [AW-1:0]              clr_addr_q;

  assign take[2] = !v_q[2] || !out_stall_i;
  assign take[1] = !v_q[1] || take[2];
  assign take[0] = !v_q[0] || take[1];

  assign f = factor_i[sdl_pkg::FactW-1] ? sdl_pkg::Unity : factor_i;

  // The level written back in this cycle is also captured in the forward
  // register and used as the previous level when the next item reads that bin.
  assign prev     = !inr_r_q ? '0 : (fwd_q ? fwd_val_q : rdata_q);
  assign sum      = lf_r_q + sdl_pkg::BlendW'(prev) * sdl_pkg::BlendW'(g_r_q);
  assign smoothed = sum[sdl_pkg::BlendW-1:sdl_pkg::BlendW-sdl_pkg::LvlW];
  assign wr_en    = take[2] && v_q[1] && inr_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q        <= '0;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      if (take[0]) begin
        v_q[0] <= in_valid_i;
      end
      if (take[1]) begin
        v_q[1] <= v_q[0];
      end
      if (take[2]) begin
        v_q[2] <= v_q[1];
      end
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == AW'(NUM_BINS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take[0]) begin
      lf_q    <= sdl_pkg::BlendW'(in_item_i.level) * sdl_pkg::BlendW'(f)
                 + sdl_pkg::BlendRound;
      g_q     <= sdl_pkg::Unity - f;
      bin_c_q <= in_item_i.bin;
      inr_c_q <= 32'(in_item_i.bin) < 32'(NUM_BINS);
    end
    if (take[1]) begin
      lf_r_q    <= lf_q;
      g_r_q     <= g_q;
      bin_r_q   <= bin_c_q;
      inr_r_q   <= inr_c_q;
      rdata_q   <= mem[AW'(bin_c_q)];
      fwd_q     <= wr_en && (bin_r_q == bin_c_q);
      fwd_val_q <= smoothed;
    end
    if (take[2]) begin
      out_bin_q   <= bin_r_q;
      out_level_q <= smoothed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en) begin
      mem[AW'(bin_r_q)] <= smoothed;
    end
  end

  assign in_stall_o  = !take[0] || clr_busy_q;
  assign out_valid_o = v_q[2];
  assign out_bin_o   = out_bin_q;
  assign out_level_o = out_level_q;
  assign clr_busy_o  = clr_busy_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !v_q[0] && !v_q[1] && !v_q[2])
    else $error("Pipeline holds a request during the clearing pass.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_busy_q |=> !clr_busy_q)
    else $error("Clearing pass restarted without reset.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_busy_q) |-> $past(clr_addr_q) == AW'(NUM_BINS - 1))
    else $error("Clearing pass ended before the last bin.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take[1] && v_q[0] && wr_en && (bin_r_q == bin_c_q) |=> fwd_q && v_q[1])
    else $error("Back-to-back update of one bin was not forwarded.");
`endif

endmodule

[design/spectrum_db_level_smoother.sv]
`timescale 1ns / 1ps

// Spectrum level smoother. Each request carries a bin index and a Q16.16
// magnitude; the block turns the magnitude into 20*log10 dB, clamps it to
// -20..+20 dB, maps it onto a Q0.16 level and blends it with that bin's
// stored level using average_factor (Q0.16, 65536 means no smoothing).
// It takes one request per cycle unless out_stall_i holds the pipeline; its
// stages are leading-one search and normalization, sixteen squaring stages
// for the log2 fraction, the dB scaling, and the per-bin read-modify-write,
// where forwarding of the write-back keeps repeated bins at full rate.
// After reset the block clears its level memory, one bin per cycle, and
// holds in_stall_o high until every bin is cleared. Bins at or above
// NUM_BINS use a previous level of zero and are not stored.
module spectrum_db_level_smoother #(
  parameter int NUM_BINS = 512
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sdl_pkg::AddrW-1:0]    paddr,
  input  logic [sdl_pkg::DataW-1:0]    pwdata,
  output logic [sdl_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sdl_pkg::BinW-1:0]     bin_index_i,
  input  logic [sdl_pkg::MagW-1:0]     magnitude_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sdl_pkg::BinW-1:0]     out_bin_index_o,
  output logic [sdl_pkg::LvlW-1:0]     smoothed_level_o
);

  logic [sdl_pkg::FactW-1:0] factor_q;

  logic                norm_stall;
  logic                norm_valid;
  logic                log_stall;
  sdl_pkg::norm_item_t norm_item;
  logic                log_valid;
  logic                lvl_stall;
  sdl_pkg::log_item_t  log_item;
  logic                lvl_valid;
  logic                blend_stall;
  sdl_pkg::lvl_item_t  lvl_item;
  logic                clr_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= sdl_pkg::Unity;
    end else if (psel && penable && pwrite && pready &&
                 paddr[sdl_pkg::AddrW-1] == sdl_pkg::RegAvgFactor) begin
      factor_q <= pwdata[sdl_pkg::FactW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[sdl_pkg::AddrW-1] == sdl_pkg::RegAvgFactor)
                  ? sdl_pkg::DataW'(factor_q) : '0;

  sdl_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i && !clr_busy),
    .in_stall_o  (norm_stall),
    .bin_i       (bin_index_i),
    .mag_i       (magnitude_i),
    .out_valid_o (norm_valid),
    .out_stall_i (log_stall),
    .out_item_o  (norm_item)
  );

  sdl_log2 u_log2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (norm_valid),
    .in_stall_o  (log_stall),
    .in_item_i   (norm_item),
    .out_valid_o (log_valid),
    .out_stall_i (lvl_stall),
    .out_item_o  (log_item)
  );

  sdl_level u_level (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (log_valid),
    .in_stall_o  (lvl_stall),
    .in_item_i   (log_item),
    .out_valid_o (lvl_valid),
    .out_stall_i (blend_stall),
    .out_item_o  (lvl_item)
  );

  sdl_blend #(
    .NUM_BINS (NUM_BINS)
  ) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .factor_i    (factor_q),
    .in_valid_i  (lvl_valid),
    .in_stall_o  (blend_stall),
    .in_item_i   (lvl_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_bin_o   (out_bin_index_o),
    .out_level_o (smoothed_level_o),
    .clr_busy_o  (clr_busy)
  );

  assign in_stall_o = norm_stall || clr_busy;

endmodule
